[rtl/core/fvnh_pkg.sv]
// Shared widths, reset values, register indexes and hash constants for the
// fractal value noise height block. No dependencies.
package fvnh_pkg;

  localparam int WORLD_W    = 24;
  localparam int BASE_W     = 16;
  localparam int SEED_W     = 32;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int OCTAVES_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ = 1'd1;

  localparam logic [SEED_W-1:0] SEED_RST = 32'd42;
  localparam logic [BASE_W-1:0] BASE_RST = 16'd3277;

  localparam logic [31:0] HASH_MUL_Y    = 32'd57;
  localparam logic [31:0] HASH_MUL_SEED = 32'd131;
  localparam logic [31:0] HASH_MUL_SQ   = 32'd15731;
  localparam logic [31:0] HASH_ADD_SQ   = 32'd789221;
  localparam logic [31:0] HASH_ADD_OUT  = 32'd1376312589;
  localparam int          HASH_SHIFT    = 13;

endpackage

[rtl/core/fractal_value_noise_height_top.sv]
// Fractal value noise height generator: top level and full pipeline.
// Depends on fvnh_pkg.
//
// Usage: present a world coordinate pair (signed Q16.8) on in_world_x and
// in_world_y with in_valid; it is taken when in_ready is high. One height
// (unsigned Q0.16) leaves on out_height with out_valid, taken on out_ready.
// The block accepts one request per cycle while out_ready keeps the output
// moving; each octave has its own lane, so the rate is set by the 12-stage
// pipeline that every lane shares, not by any loop. Each stage holds its own
// valid bit and loads when it is empty or the stage after it moves, so a
// stalled receiver fills the pipeline before in_ready drops, and bubbles
// close up. Nothing is lost or repeated.
// Configuration (seed, base_frequency) is to be written through cfg_we,
// cfg_index and cfg_wdata only while the pipeline is empty; the block does
// not enforce this. Unknown indexes are ignored. Synchronous reset clears all
// valid bits and loads seed 42 and base_frequency 3277.
module fractal_value_noise_height_top #(
  parameter int OCTAVES = fvnh_pkg::OCTAVES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [fvnh_pkg::WORLD_W-1:0]  in_world_x,
  input  logic signed [fvnh_pkg::WORLD_W-1:0]  in_world_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [fvnh_pkg::HEIGHT_W-1:0] out_height,
  input  logic                                 cfg_we,
  input  logic        [fvnh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [fvnh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fvnh_pkg::*;

  localparam int NS   = 12;
  localparam int FQW  = BASE_W + OCTAVES - 1;
  localparam int PW   = WORLD_W + FQW;
  localparam int SW   = 42;
  localparam int SUMW = SW + 1;
  localparam int NW   = SUMW + OCTAVES + 1;
  localparam int QW   = HEIGHT_W + OCTAVES;
  localparam int M    = (1 << OCTAVES) - 1;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / M);
  localparam logic signed [NW-1:0] NUM_OFS = NW'((64'd1 << 30) * M);
  localparam logic [NW-17:0] SAT_LIM = (NW-16)'(M << 16);

  logic [SEED_W-1:0] seed_r;
  logic [BASE_W-1:0] base_r;
  logic [31:0]       seed_mix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
      base_r <= BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED:      seed_r <= cfg_wdata[SEED_W-1:0];
        CFG_BASE_FREQ: base_r <= cfg_wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign seed_mix = seed_r * HASH_MUL_SEED;

  logic [NS:1] vld_r;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !vld_r[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) en[k] = !vld_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld_r[NS];

  logic signed [SW-1:0] s_lane [OCTAVES];

  logic [WORLD_W-1:0] magx, magy;
  assign magx = in_world_x[WORLD_W-1] ? WORLD_W'(-in_world_x) : in_world_x;
  assign magy = in_world_y[WORLD_W-1] ? WORLD_W'(-in_world_y) : in_world_y;

  for (genvar o = 0; o < OCTAVES; o++) begin : g_lane
    logic [FQW-1:0] freq;
    logic [PW-1:0]  pmx_r, pmy_r;
    logic           negx_r, negy_r;
    logic [31:0]    ix_nxt, iy_nxt, ix_r, iy_r;
    logic signed [16:0] fx_nxt, fy_nxt, fx_r, fy_r;
    logic signed [33:0] fxsq, fysq;
    logic [31:0]    fxx_r, fyy_r;
    logic [31:0]    n_nxt [4];
    logic [31:0]    n3_r [4];
    logic signed [19:0] tx, ty;
    logic [34:0]    utx_r, uty_r;
    logic [31:0]    n2_r [4];
    logic [31:0]    n4_r [4];
    logic [18:0]    ux4_r, uy4_r;
    logic [37:0]    uxy4_r;
    logic [31:0]    a5_r [4];
    logic [31:0]    n5_r [4];
    logic [18:0]    ux5_r, uy5_r;
    logic [21:0]    uxy5_r;
    logic [31:0]    b6 [4];
    logic signed [31:0] v6_r [4];
    logic [18:0]    ux6_r, uy6_r;
    logic [21:0]    uxy6_r;
    logic signed [32:0] d1_r, d2_r;
    logic signed [33:0] d3_r;
    logic signed [31:0] v7_r, v8_r;
    logic [18:0]    ux7_r, uy7_r;
    logic [21:0]    uxy7_r;
    logic signed [52:0] p1_r, p2_r;
    logic signed [56:0] p3_r;

    assign freq = FQW'(base_r) << o;

    always_ff @(posedge clk) begin
      if (en[1]) begin
        pmx_r  <= magx * freq;
        pmy_r  <= magy * freq;
        negx_r <= in_world_x[WORLD_W-1];
        negy_r <= in_world_y[WORLD_W-1];
      end
    end

    always_comb begin
      ix_nxt = negx_r ? -(32'(pmx_r[PW-1:24])) : 32'(pmx_r[PW-1:24]);
      iy_nxt = negy_r ? -(32'(pmy_r[PW-1:24])) : 32'(pmy_r[PW-1:24]);
      fx_nxt = negx_r ? -$signed({1'b0, pmx_r[23:8]}) : $signed({1'b0, pmx_r[23:8]});
      fy_nxt = negy_r ? -$signed({1'b0, pmy_r[23:8]}) : $signed({1'b0, pmy_r[23:8]});
      fxsq   = fx_nxt * fx_nxt;
      fysq   = fy_nxt * fy_nxt;
    end

    always_ff @(posedge clk) begin
      if (en[2]) begin
        ix_r  <= ix_nxt;
        iy_r  <= iy_nxt;
        fx_r  <= fx_nxt;
        fy_r  <= fy_nxt;
        fxx_r <= fxsq[31:0];
        fyy_r <= fysq[31:0];
      end
    end

    always_comb begin
      for (int c = 0; c < 4; c++) begin
        n_nxt[c] = (ix_r + 32'(c[0])) + (iy_r + 32'(c[1])) * HASH_MUL_Y + seed_mix;
        n_nxt[c] = (n_nxt[c] << HASH_SHIFT) ^ n_nxt[c];
      end
      tx = 20'sd196608 - ({{3{fx_r[16]}}, fx_r} <<< 1);
      ty = 20'sd196608 - ({{3{fy_r[16]}}, fy_r} <<< 1);
    end

    always_ff @(posedge clk) begin
      if (en[3]) begin
        n3_r  <= n_nxt;
        utx_r <= fxx_r[31:16] * tx[18:0];
        uty_r <= fyy_r[31:16] * ty[18:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[4]) begin
        for (int c = 0; c < 4; c++) begin
          n2_r[c] <= n3_r[c] * n3_r[c];
          n4_r[c] <= n3_r[c];
        end
        ux4_r  <= utx_r[34:16];
        uy4_r  <= uty_r[34:16];
        uxy4_r <= utx_r[34:16] * uty_r[34:16];
      end
    end

    always_ff @(posedge clk) begin
      if (en[5]) begin
        for (int c = 0; c < 4; c++) begin
          a5_r[c] <= n2_r[c] * HASH_MUL_SQ + HASH_ADD_SQ;
          n5_r[c] <= n4_r[c];
        end
        ux5_r  <= ux4_r;
        uy5_r  <= uy4_r;
        uxy5_r <= uxy4_r[37:16];
      end
    end

    always_comb begin
      for (int c = 0; c < 4; c++) b6[c] = n5_r[c] * a5_r[c] + HASH_ADD_OUT;
    end

    always_ff @(posedge clk) begin
      if (en[6]) begin
        for (int c = 0; c < 4; c++) begin
          v6_r[c] <= 32'sd1073741824 - $signed({1'b0, b6[c][30:0]});
        end
        ux6_r  <= ux5_r;
        uy6_r  <= uy5_r;
        uxy6_r <= uxy5_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en[7]) begin
        d1_r   <= 33'(v6_r[1]) - 33'(v6_r[0]);
        d2_r   <= 33'(v6_r[2]) - 33'(v6_r[0]);
        d3_r   <= 34'(v6_r[0]) - 34'(v6_r[1]) - 34'(v6_r[2]) + 34'(v6_r[3]);
        v7_r   <= v6_r[0];
        ux7_r  <= ux6_r;
        uy7_r  <= uy6_r;
        uxy7_r <= uxy6_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en[8]) begin
        p1_r <= $signed({1'b0, ux7_r}) * d1_r;
        p2_r <= $signed({1'b0, uy7_r}) * d2_r;
        p3_r <= $signed({1'b0, uxy7_r}) * d3_r;
        v8_r <= v7_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en[9]) begin
        s_lane[o] <= SW'(v8_r) + SW'(p1_r >>> 16) + SW'(p2_r >>> 16)
                   + SW'(p3_r >>> 16);
      end
    end
  end

  logic signed [SUMW-1:0] acc;
  logic signed [NW-1:0]   num_r;

  always_comb begin
    acc = '0;
    for (int o = 0; o < OCTAVES; o++) acc = acc + (SUMW'(s_lane[o]) >>> o);
  end

  always_ff @(posedge clk) begin
    if (en[10]) num_r <= (NW'(acc) <<< (OCTAVES - 1)) + NUM_OFS;
  end

  logic [NW-17:0]   qfull;
  logic             neg_r, sat_r;
  logic [QW-1:0]    q_r;
  logic [QW+32:0]   eprod_r;

  assign qfull = num_r[NW-2:15];

  always_ff @(posedge clk) begin
    if (en[11]) begin
      neg_r   <= num_r[NW-1];
      sat_r   <= qfull >= SAT_LIM;
      q_r     <= qfull[QW-1:0];
      eprod_r <= qfull[QW-1:0] * RECIP;
    end
  end

  logic [QW-1:0] est, rem;
  logic [HEIGHT_W-1:0] height_r;

  always_comb begin
    est = eprod_r[QW+31:32];
    rem = q_r - QW'(est * QW'(M));
    if (rem >= QW'(M)) est = est + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      priority if (neg_r) height_r <= '0;
      else if (sat_r)     height_r <= '1;
      else                height_r <= est[HEIGHT_W-1:0];
    end
  end

  assign out_height = height_r;

endmodule

[rtl/core/fvnh_check.sv]
// Port-level checks for the fractal value noise height top level, with the
// bind that attaches them. Depends on fvnh_pkg.
module fvnh_check (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic        [fvnh_pkg::HEIGHT_W-1:0]   out_height
);
  import fvnh_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_height))
    else $error("stalled result dropped or changed");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_stall_blocks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

endmodule

bind fractal_value_noise_height_top fvnh_check u_fvnh_check (.*);
